// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CHK_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define CHK_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

// ===== hdl/wms_pkg.sv =====
// ----------------------------------------------------------------------------
// wms_pkg
// Beat types and fixed field widths of the window median select block.
// ----------------------------------------------------------------------------
`default_nettype none

package wms_pkg;

    localparam int SAMPLE_W = 8;
    localparam int COUNT_W  = 8;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                is_last;
    } wms_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] median_value;
        logic [COUNT_W-1:0]  window_count;
        logic                overflowed;
    } wms_out_t;

endpackage

`default_nettype wire

// ===== hdl/wms_store.sv =====
// ----------------------------------------------------------------------------
// wms_store
// Sample memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wms_store #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic [wms_pkg::SAMPLE_W-1:0] wr_data,
    input  wire logic                         rd_en,
    input  wire logic [AW-1:0]                rd_addr,
    output      logic [wms_pkg::SAMPLE_W-1:0] rd_data
);
    import wms_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/wms_select.sv =====
// ----------------------------------------------------------------------------
// wms_select
// Rank selection by bitwise search: one pass over the stored window per
// value bit, counting entries at or below the trial threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module wms_select #(
    parameter int AW = 7,
    parameter int CW = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         go,
    input  wire logic [CW-1:0]                n,
    output      logic                         rd_en,
    output      logic [AW-1:0]                rd_addr,
    input  wire logic [wms_pkg::SAMPLE_W-1:0] rd_data,
    output      logic                         done,
    output      logic [wms_pkg::SAMPLE_W-1:0] value
);
    import wms_pkg::*;

    localparam int BW = $clog2(SAMPLE_W);

    logic                run_reg,    run_next;
    logic [CW-1:0]       n_reg,      n_next;
    logic [CW-1:0]       k_reg,      k_next;
    logic [CW-1:0]       idx_reg,    idx_next;
    logic                rdv_reg,    rdv_next;
    logic [CW-1:0]       cnt_reg,    cnt_next;
    logic [BW-1:0]       bit_reg,    bit_next;
    logic [SAMPLE_W-1:0] prefix_reg, prefix_next;

    logic [SAMPLE_W-1:0] low_mask;
    logic [SAMPLE_W-1:0] thr;
    logic [SAMPLE_W-1:0] decided;
    logic                issue;
    logic                pass_end;

    // Trial value: bit under test cleared, all bits below set.
    assign low_mask = SAMPLE_W'(({1'b0, {SAMPLE_W{1'b1}}}) >> (SAMPLE_W - int'(bit_reg)));
    assign thr      = prefix_reg | low_mask;
    assign issue    = run_reg && (idx_reg < n_reg);
    assign pass_end = run_reg && (idx_reg == n_reg) && !rdv_reg;
    assign decided  = (cnt_reg > k_reg) ? prefix_reg
                                        : (prefix_reg | (SAMPLE_W'(1) << bit_reg));

    assign rd_en   = issue;
    assign rd_addr = idx_reg[AW-1:0];
    assign done    = pass_end && (bit_reg == '0);
    assign value   = decided;

    always_comb
    begin
        run_next    = run_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        idx_next    = idx_reg;
        rdv_next    = issue;
        cnt_next    = cnt_reg;
        bit_next    = bit_reg;
        prefix_next = prefix_reg;

        if (go)
        begin
            run_next    = 1'b1;
            n_next      = n;
            k_next      = n >> 1;
            idx_next    = '0;
            cnt_next    = '0;
            bit_next    = BW'(SAMPLE_W - 1);
            prefix_next = '0;
        end
        else if (run_reg)
        begin
            if (issue)
            begin
                idx_next = idx_reg + 1'b1;
            end
            if (rdv_reg && (rd_data <= thr))
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (pass_end)
            begin
                prefix_next = decided;
                idx_next    = '0;
                cnt_next    = '0;
                if (bit_reg == '0)
                begin
                    run_next = 1'b0;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            rdv_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            rdv_reg <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        k_reg      <= k_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        bit_reg    <= bit_next;
        prefix_reg <= prefix_next;
    end

endmodule

`default_nettype wire

// ===== hdl/window_median_select_top.sv =====
// ----------------------------------------------------------------------------
// window_median_select_top
// Median of a window of 8-bit samples, picked from an on-chip sample memory.
// ----------------------------------------------------------------------------
// channel  | handshake            | beat type
// input    | start / busy         | wms_in_t  item
// result   | done (one-cycle)     | wms_out_t result
//
// A sample that is not last leaves busy low, so the next sample is not blocked.
// The last sample starts the search: 8 passes over the window, each reading
// every stored sample, draining the last read and deciding one bit. Busy is
// high through the search; done pulses in the same cycle busy falls. The
// single memory read port sets the length of each pass. Reset clears count,
// overflow and control; the memory holds no reset. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module window_median_select_top #(
    parameter int MAX_WINDOW = 128
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output      logic              busy,
    input  wire wms_pkg::wms_in_t  item,
    output      logic              done,
    output      wms_pkg::wms_out_t result
);
    import wms_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);

    localparam logic ST_LOAD   = 1'b0;
    localparam logic ST_SELECT = 1'b1;

    logic           state_reg,  state_next;
    logic [CW-1:0]  cnt_reg,    cnt_next;
    logic           ov_reg,     ov_next;
    logic           done_reg,   done_next;
    wms_out_t       result_reg, result_next;

    logic                accept;
    logic                full;
    logic                go;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [SAMPLE_W-1:0] rd_data;
    logic                sel_done;
    logic [SAMPLE_W-1:0] sel_value;

    assign busy   = (state_reg == ST_SELECT);
    assign accept = start && !busy;
    assign full   = (cnt_reg == CW'(MAX_WINDOW));
    assign go     = accept && item.is_last;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ov_next     = ov_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    // drop the beat once the store is full
                    if (full)
                    begin
                        ov_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (item.is_last)
                    begin
                        state_next = ST_SELECT;
                    end
                end
            end
            ST_SELECT:
            begin
                if (sel_done)
                begin
                    done_next                = 1'b1;
                    result_next.median_value = sel_value;
                    result_next.window_count = COUNT_W'(cnt_reg);
                    result_next.overflowed   = ov_reg;
                    cnt_next                 = '0;
                    ov_next                  = 1'b0;
                    state_next               = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    wms_store #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && !full),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (item.sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wms_select #(
        .AW (AW),
        .CW (CW)
    ) u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .n       (cnt_next),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .done    (sel_done),
        .value   (sel_value)
    );

endmodule

`default_nettype wire

// ===== hdl/wms_checker.sv =====
// ----------------------------------------------------------------------------
// wms_checker
// Port-level checks of the window median select block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wms_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire wms_pkg::wms_in_t  item,
    input wire logic              done,
    input wire wms_pkg::wms_out_t result
);
    import wms_pkg::*;

    // a result only shows once the search has let go of the block
    `CHK_NOW(a_done_idle, clk, rst_n, done, !busy)
    // each result needs a new search, so results never come back to back
    `CHK_NEXT(a_done_single, clk, rst_n, done, !done)
    // a beat that is not last never blocks the next one
    `CHK_NEXT(a_mid_free, clk, rst_n, start && !busy && !item.is_last, !busy && !done)
    // the last beat starts the search
    `CHK_NEXT(a_last_busy, clk, rst_n, start && !busy && item.is_last, busy)
    // a result beat carries only stored samples and reset-cleared state
    `CHK_NOW(a_result_known, clk, rst_n, done, !$isunknown(result))

endmodule

bind window_median_select_top wms_checker u_wms_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

`default_nettype wire
